[src/awpid_pkg.sv]
package awpid_pkg;

  localparam int GAIN_WIDTH      = 24;
  localparam int LIMIT_WIDTH     = 23;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int CFG_INDEX_WIDTH = 3;

  // half and full turn in 1/128 degree steps
  localparam int HALF_TURN = 23040;
  localparam int FULL_TURN = 46080;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUTPUT_LIMIT   = 3'd4;

  localparam logic [GAIN_WIDTH-1:0]  RESET_PROP_GAIN      = 24'd98304;
  localparam logic [GAIN_WIDTH-1:0]  RESET_INTEG_GAIN     = 24'd66;
  localparam logic [GAIN_WIDTH-1:0]  RESET_DERIV_GAIN     = 24'd131072;
  localparam logic [LIMIT_WIDTH-1:0] RESET_INTEGRAL_LIMIT = 23'd1792;
  localparam logic [LIMIT_WIDTH-1:0] RESET_OUTPUT_LIMIT   = 23'd46080;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  prop_gain;
    logic [GAIN_WIDTH-1:0]  integ_gain;
    logic [GAIN_WIDTH-1:0]  deriv_gain;
    logic [LIMIT_WIDTH-1:0] integral_limit;
    logic [LIMIT_WIDTH-1:0] output_limit;
  } cfg_t;

endpackage

[src/awpid_error.sv]
module awpid_error #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic signed [ANGLE_WIDTH-1:0] target_angle,
  input  logic signed [ANGLE_WIDTH-1:0] measured_angle,
  output logic signed [ANGLE_WIDTH-1:0] err,
  output logic signed [ANGLE_WIDTH:0]   err_diff
);
  import awpid_pkg::*;

  localparam int DW = ANGLE_WIDTH + 1;
  localparam int WW = ((DW > 17) ? DW : 17) + 1;
  localparam logic signed [WW-1:0] HALF  = WW'(HALF_TURN);
  localparam logic signed [WW-1:0] NHALF = -HALF;
  localparam logic signed [WW-1:0] FULL  = WW'(FULL_TURN);
  localparam logic signed [WW-1:0] AMAX  = WW'({(ANGLE_WIDTH-1){1'b1}});
  localparam logic signed [WW-1:0] AMIN  = ~AMAX;

  logic signed [WW-1:0]          raw;
  logic signed [WW-1:0]          wrapped;
  logic signed [ANGLE_WIDTH-1:0] err_next;
  logic signed [ANGLE_WIDTH-1:0] prev_error;

  always_comb begin
    raw = WW'(target_angle) - WW'(measured_angle);
    // one wrap only; exactly a half turn stays as is
    if (raw < NHALF) begin
      wrapped = raw + FULL;
    end else if (raw > HALF) begin
      wrapped = raw - FULL;
    end else begin
      wrapped = raw;
    end
    if (wrapped > AMAX) begin
      err_next = AMAX[ANGLE_WIDTH-1:0];
    end else if (wrapped < AMIN) begin
      err_next = AMIN[ANGLE_WIDTH-1:0];
    end else begin
      err_next = wrapped[ANGLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      err      <= err_next;
      err_diff <= DW'(err_next) - DW'(prev_error);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (load) begin
      prev_error <= err_next;
    end
  end

`ifndef SYNTHESIS
  a_prev_tracks_err: assert property (@(posedge clk) disable iff (rst)
    load |=> prev_error == err)
    else $error("previous error out of step with stage error");

  a_prev_holds: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(prev_error))
    else $error("previous error changed without a transaction");
`endif

endmodule

[src/awpid_mult.sv]
module awpid_mult #(
  parameter int ANGLE_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [ANGLE_WIDTH-1:0] err,
  input  logic signed [ANGLE_WIDTH:0]   err_diff,
  input  awpid_pkg::cfg_t               cfg,
  output logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] p_term,
  output logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] d_term,
  output logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] i_step,
  output logic signed [ANGLE_WIDTH-1:0] err_out
);
  import awpid_pkg::*;

  localparam int PW = ANGLE_WIDTH + GAIN_WIDTH + 2;
  localparam int SW = PW - (GAIN_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (GAIN_FRAC_BITS - 2);

  logic signed [GAIN_WIDTH:0] pg;
  logic signed [GAIN_WIDTH:0] ig;
  logic signed [GAIN_WIDTH:0] dg;
  logic signed [PW-1:0]       p_prod;
  logic signed [PW-1:0]       i_prod;
  logic signed [PW-1:0]       d_prod;

  // round half up, then floor shift down to 8 fraction bits
  function automatic logic signed [SW-1:0] scale(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] r;
    r = prod + RND;
    return r[PW-1:GAIN_FRAC_BITS-1];
  endfunction

  always_comb begin
    pg     = {1'b0, cfg.prop_gain};
    ig     = {1'b0, cfg.integ_gain};
    dg     = {1'b0, cfg.deriv_gain};
    p_prod = err * pg;
    i_prod = err * ig;
    d_prod = err_diff * dg;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_term  <= scale(p_prod);
      i_step  <= scale(i_prod);
      d_term  <= scale(d_prod);
      err_out <= err;
    end
  end

endmodule

[src/awpid_accum.sv]
module awpid_accum #(
  parameter int ANGLE_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int OUTPUT_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] p_term,
  input  logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] d_term,
  input  logic signed [ANGLE_WIDTH+awpid_pkg::GAIN_WIDTH+2-GAIN_FRAC_BITS:0] i_step,
  input  logic signed [ANGLE_WIDTH-1:0]  err,
  input  awpid_pkg::cfg_t                cfg,
  output logic signed [OUTPUT_WIDTH-1:0] drive,
  output logic signed [ANGLE_WIDTH-1:0]  wrapped_error,
  output logic                           integral_clamped,
  output logic                           output_clamped
);
  import awpid_pkg::*;

  localparam int SW = ANGLE_WIDTH + GAIN_WIDTH + 3 - GAIN_FRAC_BITS;
  localparam int XW = ((SW > OUTPUT_WIDTH) ? SW : OUTPUT_WIDTH) + 2;
  localparam int LW = (LIMIT_WIDTH > OUTPUT_WIDTH) ? LIMIT_WIDTH : OUTPUT_WIDTH;

  logic signed [OUTPUT_WIDTH-1:0] integral_sum;
  logic        [OUTPUT_WIDTH-1:0] ilim;
  logic        [OUTPUT_WIDTH-1:0] olim;
  logic signed [XW-1:0]           integ_next;
  logic signed [XW-1:0]           sum;
  logic signed [XW-1:0]           drive_next;
  logic                           ihit;
  logic                           ohit;

  // limit saturates to the largest positive result value
  function automatic logic [OUTPUT_WIDTH-1:0] lim_eff(input logic [LIMIT_WIDTH-1:0] limit);
    logic [LW-1:0] l;
    logic [LW-1:0] top;
    l   = LW'(limit);
    top = LW'({(OUTPUT_WIDTH-1){1'b1}});
    return OUTPUT_WIDTH'((l > top) ? top : l);
  endfunction

  function automatic logic signed [XW-1:0] clamp_sym(input logic signed [XW-1:0] v,
                                                     input logic [OUTPUT_WIDTH-1:0] lim,
                                                     output logic hit);
    logic signed [XW-1:0] lp;
    logic signed [XW-1:0] ln;
    lp  = $signed(XW'(lim));
    ln  = -lp;
    hit = 1'b0;
    if (v > lp) begin
      hit = 1'b1;
      return lp;
    end
    if (v < ln) begin
      hit = 1'b1;
      return ln;
    end
    return v;
  endfunction

  always_comb begin
    ilim       = lim_eff(cfg.integral_limit);
    olim       = lim_eff(cfg.output_limit);
    integ_next = clamp_sym(XW'(integral_sum) + XW'(i_step), ilim, ihit);
    sum        = XW'(p_term) + XW'(d_term) + integ_next;
    drive_next = clamp_sym(sum, olim, ohit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (load) begin
      integral_sum <= integ_next[OUTPUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive            <= drive_next[OUTPUT_WIDTH-1:0];
      wrapped_error    <= err;
      integral_clamped <= ihit;
      output_clamped   <= ohit;
    end
  end

`ifndef SYNTHESIS
  a_drive_at_limit: assert property (@(posedge clk) disable iff (rst)
    load |=> !output_clamped || drive == $signed($past(olim))
             || drive == -$signed($past(olim)))
    else $error("drive flagged as clamped but not at the output limit");

  a_integral_at_limit: assert property (@(posedge clk) disable iff (rst)
    load |=> !integral_clamped || integral_sum == $signed($past(ilim))
             || integral_sum == -$signed($past(ilim)))
    else $error("integral flagged as clamped but not at the integral limit");
`endif

endmodule

[src/angle_wrap_pid_controller.sv]
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// input    | in_valid / in_ready  | target_angle, measured_angle
// output   | out_valid / out_ready| drive, wrapped_error, integral_clamped,
//          |                      | output_clamped
// config   | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// one transaction per cycle sustained while the output is not stalled; a taken input passes
// through the error register, product register and result register in turn
// the integral and previous error recurrences each close within one stage
// rst is synchronous: clears stage valids, previous error and integral, loads default gains and limits
// a stalled output holds only the stages behind it that are full; empty stages keep accepting
module angle_wrap_pid_controller #(
  parameter int ANGLE_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int OUTPUT_WIDTH   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [awpid_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [awpid_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ANGLE_WIDTH-1:0]         target_angle,
  input  logic signed [ANGLE_WIDTH-1:0]         measured_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [OUTPUT_WIDTH-1:0]        drive,
  output logic signed [ANGLE_WIDTH-1:0]         wrapped_error,
  output logic                                  integral_clamped,
  output logic                                  output_clamped
);
  import awpid_pkg::*;

  localparam int SW = ANGLE_WIDTH + GAIN_WIDTH + 3 - GAIN_FRAC_BITS;

  cfg_t cfg;

  logic valid_a;
  logic valid_b;
  logic valid_c;
  logic ready_b;
  logic ready_c;
  logic load_a;
  logic load_b;
  logic load_c;

  logic signed [ANGLE_WIDTH-1:0] err_a;
  logic signed [ANGLE_WIDTH:0]   diff_a;
  logic signed [ANGLE_WIDTH-1:0] err_b;
  logic signed [SW-1:0]          p_b;
  logic signed [SW-1:0]          d_b;
  logic signed [SW-1:0]          i_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= RESET_PROP_GAIN;
      cfg.integ_gain     <= RESET_INTEG_GAIN;
      cfg.deriv_gain     <= RESET_DERIV_GAIN;
      cfg.integral_limit <= RESET_INTEGRAL_LIMIT;
      cfg.output_limit   <= RESET_OUTPUT_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[GAIN_WIDTH-1:0];
        CFG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[GAIN_WIDTH-1:0];
        CFG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[GAIN_WIDTH-1:0];
        CFG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage moves when the one after it is empty or moving
  always_comb begin
    ready_c   = !valid_c || out_ready;
    ready_b   = !valid_b || ready_c;
    in_ready  = !valid_a || ready_b;
    load_a    = in_valid && in_ready;
    load_b    = valid_a && ready_b;
    load_c    = valid_b && ready_c;
    out_valid = valid_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_a <= in_valid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
      if (ready_c) begin
        valid_c <= valid_b;
      end
    end
  end

  awpid_error #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_error (
    .clk           (clk),
    .rst           (rst),
    .load          (load_a),
    .target_angle  (target_angle),
    .measured_angle(measured_angle),
    .err           (err_a),
    .err_diff      (diff_a)
  );

  awpid_mult #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mult (
    .clk     (clk),
    .load    (load_b),
    .err     (err_a),
    .err_diff(diff_a),
    .cfg     (cfg),
    .p_term  (p_b),
    .d_term  (d_b),
    .i_step  (i_b),
    .err_out (err_b)
  );

  awpid_accum #(
    .ANGLE_WIDTH   (ANGLE_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .OUTPUT_WIDTH  (OUTPUT_WIDTH)
  ) u_accum (
    .clk             (clk),
    .rst             (rst),
    .load            (load_c),
    .p_term          (p_b),
    .d_term          (d_b),
    .i_step          (i_b),
    .err             (err_b),
    .cfg             (cfg),
    .drive           (drive),
    .wrapped_error   (wrapped_error),
    .integral_clamped(integral_clamped),
    .output_clamped  (output_clamped)
  );

endmodule
